// ----- sv/crc16df_pkg.sv -----
// ============================================================================
// crc16df_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// framed packet deframer.
// ============================================================================
package crc16df_pkg;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC  = 2'd2;

    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;

    localparam logic [7:0]  HEADER_FIRST_RESET  = 8'hAA;
    localparam logic [7:0]  HEADER_SECOND_RESET = 8'h55;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'h1021;

    typedef enum logic [3:0] {
        ST_HDR0,
        ST_HDR1,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CRCLO,
        ST_CRCHI,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef enum logic [1:0] {
        OUT_DATA,
        OUT_EMPTY,
        OUT_OVERSIZE,
        OUT_BAD_CRC
    } out_kind_t;

    typedef struct packed {
        logic      restart;
        logic      crc_init;
        logic      load_type;
        logic      load_len;
        logic      store_data;
        logic      load_crc_lo;
        logic      load_rcrc;
        logic      rd_clear;
        logic      rd_fetch;
        logic      rd_advance;
        logic      out_load;
        out_kind_t out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_first_match;
        logic hdr_second_match;
        logic len_oversize;
        logic len_zero;
        logic held_len_zero;
        logic fill_done;
        logic crc_match;
        logic rd_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/crc16df_ctrl.sv -----
// ============================================================================
// crc16df_ctrl
// Parser state machine: walks the frame fields, issues datapath commands and
// sequences the payload read-out after a good CRC.
// ============================================================================
module crc16df_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  crc16df_pkg::dp_sts_t sts,
    output crc16df_pkg::dp_cmd_t cmd
);

    crc16df_pkg::state_t state_reg;
    crc16df_pkg::state_t state_next;
    logic                take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crc16df_pkg::ST_HDR0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = crc16df_pkg::OUT_DATA;
        in_stall     = 1'b0;
        take         = 1'b0;
        unique case (state_reg)
            crc16df_pkg::ST_HDR0:
            begin
                take = in_valid;
                if (take && sts.hdr_first_match)
                begin
                    state_next = crc16df_pkg::ST_HDR1;
                end
            end
            crc16df_pkg::ST_HDR1:
            begin
                take = in_valid;
                if (take)
                begin
                    if (sts.hdr_second_match)
                    begin
                        cmd.crc_init = 1'b1;
                        state_next   = crc16df_pkg::ST_TYPE;
                    end
                    else if (!sts.hdr_first_match)
                    begin
                        state_next = crc16df_pkg::ST_HDR0;
                    end
                end
            end
            crc16df_pkg::ST_TYPE:
            begin
                take = in_valid;
                if (take)
                begin
                    cmd.load_type = 1'b1;
                    state_next    = crc16df_pkg::ST_LEN;
                end
            end
            crc16df_pkg::ST_LEN:
            begin
                in_stall = !sts.out_free;
                take     = in_valid && sts.out_free;
                if (take)
                begin
                    if (sts.len_oversize)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = crc16df_pkg::OUT_OVERSIZE;
                        cmd.restart  = 1'b1;
                        state_next   = crc16df_pkg::ST_HDR0;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = sts.len_zero ? crc16df_pkg::ST_CRCLO
                                                    : crc16df_pkg::ST_DATA;
                    end
                end
            end
            crc16df_pkg::ST_DATA:
            begin
                take = in_valid;
                if (take)
                begin
                    cmd.store_data = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = crc16df_pkg::ST_CRCLO;
                    end
                end
            end
            crc16df_pkg::ST_CRCLO:
            begin
                take = in_valid;
                if (take)
                begin
                    cmd.load_crc_lo = 1'b1;
                    state_next      = crc16df_pkg::ST_CRCHI;
                end
            end
            crc16df_pkg::ST_CRCHI:
            begin
                in_stall = !sts.out_free;
                take     = in_valid && sts.out_free;
                if (take)
                begin
                    cmd.load_rcrc = 1'b1;
                    if (!sts.crc_match)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = crc16df_pkg::OUT_BAD_CRC;
                        cmd.restart  = 1'b1;
                        state_next   = crc16df_pkg::ST_HDR0;
                    end
                    else if (sts.held_len_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = crc16df_pkg::OUT_EMPTY;
                        cmd.restart  = 1'b1;
                        state_next   = crc16df_pkg::ST_HDR0;
                    end
                    else
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = crc16df_pkg::ST_EMIT_RD;
                    end
                end
            end
            crc16df_pkg::ST_EMIT_RD:
            begin
                in_stall     = 1'b1;
                cmd.rd_fetch = 1'b1;
                state_next   = crc16df_pkg::ST_EMIT_WR;
            end
            crc16df_pkg::ST_EMIT_WR:
            begin
                in_stall = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = crc16df_pkg::OUT_DATA;
                    if (sts.rd_last)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = crc16df_pkg::ST_HDR0;
                    end
                    else
                    begin
                        cmd.rd_advance = 1'b1;
                        state_next     = crc16df_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                cmd.restart = 1'b1;
                state_next  = crc16df_pkg::ST_HDR0;
            end
        endcase
    end

    // The read-out phase never takes input bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crc16df_pkg::ST_EMIT_RD || state_reg == crc16df_pkg::ST_EMIT_WR)
        |-> in_stall)
        else $error("input accepted during payload read-out");

    // A result is only loaded into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");

    // A memory fetch is always followed by its output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crc16df_pkg::ST_EMIT_RD) |=> (state_reg == crc16df_pkg::ST_EMIT_WR))
        else $error("payload fetch not followed by output step");

    // Accepting a byte and stalling are exclusive.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !in_stall)
        else $error("byte taken while input stalled");

endmodule

// ----- sv/crc16df_dp.sv -----
// ============================================================================
// crc16df_dp
// Datapath: header registers, frame field registers, running CRC, payload
// memory and the output register.
// ============================================================================
module crc16df_dp
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  crc16df_pkg::dp_cmd_t cmd,
    output crc16df_pkg::dp_sts_t sts,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [1:0]           status,
    output logic [7:0]           packet_type,
    output logic [5:0]           packet_length,
    output logic [4:0]           byte_index,
    output logic [7:0]           data_byte,
    output logic                 data_valid,
    output logic [15:0]          received_crc,
    output logic                 last
);

    localparam int         LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int         ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_B  = 8'(MAX_PAYLOAD);

    logic [7:0]       hdr_first_reg;
    logic [7:0]       hdr_second_reg;
    logic [7:0]       held_type_reg;
    logic [LEN_W-1:0] held_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic [7:0]       crc_lo_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      rcrc_reg;
    logic [15:0]      rcrc_next;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] rd_idx_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [MAX_PAYLOAD];
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [7:0]       packet_type_reg;
    logic [5:0]       packet_length_reg;
    logic [4:0]       byte_index_reg;
    logic [7:0]       data_byte_reg;
    logic             data_valid_reg;
    logic [15:0]      received_crc_reg;
    logic             last_reg;

    assign crc_next    = crc16df_pkg::crc_absorb(crc_reg, rx_byte);
    assign rcrc_next   = {rx_byte, crc_lo_reg};
    assign fill_next   = fill_reg + LEN_W'(1);
    assign rd_idx_next = rd_idx_reg + LEN_W'(1);

    assign sts.hdr_first_match  = (rx_byte == hdr_first_reg);
    assign sts.hdr_second_match = (rx_byte == hdr_second_reg);
    assign sts.len_oversize     = (rx_byte > MAX_B);
    assign sts.len_zero         = (rx_byte == 8'd0);
    assign sts.held_len_zero    = (held_len_reg == '0);
    assign sts.fill_done        = (fill_next >= held_len_reg);
    assign sts.crc_match        = (rcrc_next == crc_reg);
    assign sts.rd_last          = (rd_idx_next == held_len_reg);
    assign sts.out_free         = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= crc16df_pkg::HEADER_FIRST_RESET;
            hdr_second_reg <= crc16df_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == crc16df_pkg::CFG_HEADER_FIRST)
            begin
                hdr_first_reg <= cfg_data;
            end
            else if (cfg_index == crc16df_pkg::CFG_HEADER_SECOND)
            begin
                hdr_second_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_type_reg <= '0;
            held_len_reg  <= '0;
            fill_reg      <= '0;
            crc_lo_reg    <= '0;
            crc_reg       <= crc16df_pkg::CRC_INIT;
        end
        else if (cmd.restart)
        begin
            held_type_reg <= '0;
            held_len_reg  <= '0;
            fill_reg      <= '0;
            crc_lo_reg    <= '0;
            crc_reg       <= crc16df_pkg::CRC_INIT;
        end
        else
        begin
            if (cmd.crc_init)
            begin
                crc_reg <= crc16df_pkg::CRC_INIT;
            end
            if (cmd.load_type)
            begin
                held_type_reg <= rx_byte;
                crc_reg       <= crc_next;
            end
            if (cmd.load_len)
            begin
                held_len_reg <= LEN_W'(rx_byte);
                fill_reg     <= '0;
                crc_reg      <= crc_next;
            end
            if (cmd.store_data)
            begin
                fill_reg <= fill_next;
                crc_reg  <= crc_next;
            end
            if (cmd.load_crc_lo)
            begin
                crc_lo_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_clear)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rcrc)
        begin
            rcrc_reg <= rcrc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_data)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_fetch)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            packet_type_reg <= held_type_reg;
            unique case (cmd.out_kind)
                crc16df_pkg::OUT_DATA:
                begin
                    status_reg        <= crc16df_pkg::STATUS_GOOD;
                    packet_length_reg <= 6'(held_len_reg);
                    byte_index_reg    <= 5'(rd_idx_reg);
                    data_byte_reg     <= rd_data_reg;
                    data_valid_reg    <= 1'b1;
                    received_crc_reg  <= rcrc_reg;
                    last_reg          <= sts.rd_last;
                end
                crc16df_pkg::OUT_EMPTY:
                begin
                    status_reg        <= crc16df_pkg::STATUS_GOOD;
                    packet_length_reg <= '0;
                    byte_index_reg    <= '0;
                    data_byte_reg     <= '0;
                    data_valid_reg    <= 1'b0;
                    received_crc_reg  <= rcrc_next;
                    last_reg          <= 1'b1;
                end
                crc16df_pkg::OUT_OVERSIZE:
                begin
                    status_reg        <= crc16df_pkg::STATUS_OVERSIZE;
                    packet_length_reg <= '0;
                    byte_index_reg    <= '0;
                    data_byte_reg     <= '0;
                    data_valid_reg    <= 1'b0;
                    received_crc_reg  <= '0;
                    last_reg          <= 1'b1;
                end
                crc16df_pkg::OUT_BAD_CRC:
                begin
                    status_reg        <= crc16df_pkg::STATUS_BAD_CRC;
                    packet_length_reg <= 6'(held_len_reg);
                    byte_index_reg    <= '0;
                    data_byte_reg     <= '0;
                    data_valid_reg    <= 1'b0;
                    received_crc_reg  <= rcrc_next;
                    last_reg          <= 1'b1;
                end
                default:
                begin
                    status_reg        <= crc16df_pkg::STATUS_GOOD;
                    packet_length_reg <= '0;
                    byte_index_reg    <= '0;
                    data_byte_reg     <= '0;
                    data_valid_reg    <= 1'b0;
                    received_crc_reg  <= '0;
                    last_reg          <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign packet_type   = packet_type_reg;
    assign packet_length = packet_length_reg;
    assign byte_index    = byte_index_reg;
    assign data_byte     = data_byte_reg;
    assign data_valid    = data_valid_reg;
    assign received_crc  = received_crc_reg;
    assign last          = last_reg;

    // The payload is written in order and never past the announced length.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_data |-> (fill_reg < held_len_reg))
        else $error("payload write beyond packet length");

    // Read-out never runs past the stored payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_fetch |-> (rd_idx_reg < held_len_reg))
        else $error("payload read beyond packet length");

    // A loaded result is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ----- sv/crc16_packet_deframer.sv -----
// ============================================================================
// crc16_packet_deframer
// Received bytes are taken one per cycle while the block is parsing a frame
// (header, type, length, payload, CRC low and high byte), each through the
// parser state machine; the type, length and payload bytes also update the
// running CRC-16. A good packet with a nonempty payload then stalls the
// input while the payload is read back: for each result the payload memory
// is read into a register and then the output register is loaded, which
// waits while the output is stalled. Oversize-length, CRC-mismatch and
// empty-packet results go out through the same output register; the length
// byte and the CRC high byte are held off only while an earlier result
// still waits there. Configuration writes are always ready and should only
// be issued while no frame is in progress.
// ============================================================================
module crc16_packet_deframer
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  packet_type,
    output logic [5:0]  packet_length,
    output logic [4:0]  byte_index,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic [15:0] received_crc,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    crc16df_pkg::dp_cmd_t cmd;
    crc16df_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    crc16df_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    crc16df_dp
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .packet_type   (packet_type),
        .packet_length (packet_length),
        .byte_index    (byte_index),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .received_crc  (received_crc),
        .last          (last)
    );

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench
// Self-checking test of crc16_packet_deframer. A driver sends received bytes
// from a queue, and a monitor checks every output transaction field by field
// against a cycle-free predictor of the frame parser and its CRC-16 check.
// The run goes through several header settings. It combines random sender
// gaps and receiver stalls with one long receiver hold-off.
// ============================================================================
module testbench;

    localparam int MAX_PAYLOAD    = 32;
    localparam int PHASE_BYTES    = 50;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 2 * MAX_PAYLOAD + 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  ptype;
        logic [5:0]  plen;
        logic [4:0]  index;
        logic [7:0]  data;
        logic        dvalid;
        logic [15:0] rcrc;
        logic        last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  packet_type;
    logic [5:0]  packet_length;
    logic [4:0]  byte_index;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [15:0] received_crc;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'h00;

    logic [7:0]    pending_bytes[$];
    logic [7:0]    frame_body[$];
    frame_result_t expected_results[$];

    logic [7:0]           hdr_first = crc16df_pkg::HEADER_FIRST_RESET;
    logic [7:0]           hdr_second = crc16df_pkg::HEADER_SECOND_RESET;
    crc16df_pkg::state_t  parse_state = crc16df_pkg::ST_HDR0;
    logic [7:0]           held_type = 8'h00;
    logic [5:0]           held_len = 6'd0;
    logic [5:0]           fill_count = 6'd0;
    logic [7:0]           crc_lo = 8'h00;
    logic [15:0]          run_crc = crc16df_pkg::CRC_INIT;
    logic [7:0]           payload_copy[MAX_PAYLOAD];

    bit no_idle = 1'b0;
    bit byte_taken = 1'b0;
    bit out_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int good_packets = 0;
    int empty_packets = 0;
    int oversize_drops = 0;
    int crc_drops = 0;
    int header_settings = 1;
    int reg_writes = 0;

    crc16_packet_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .packet_type(packet_type),
        .packet_length(packet_length),
        .byte_index(byte_index),
        .data_byte(data_byte),
        .data_valid(data_valid),
        .received_crc(received_crc),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int k = 7; k >= 0; k--)
        begin
            feedback = acc[15] ^ b[k];
            acc = {acc[14:0], 1'b0} ^ (feedback ? crc16df_pkg::CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    task automatic expect_result(input logic [1:0] st, input logic [5:0] len,
                                 input logic [4:0] idx, input logic [7:0] data,
                                 input logic dvalid, input logic [15:0] rcrc,
                                 input logic is_last);
        frame_result_t r;
        r.status = st;
        r.ptype  = held_type;
        r.plen   = len;
        r.index  = idx;
        r.data   = data;
        r.dvalid = dvalid;
        r.rcrc   = rcrc;
        r.last   = is_last;
        expected_results.push_back(r);
    endtask

    task automatic restart_parser();
        parse_state = crc16df_pkg::ST_HDR0;
        held_type   = 8'h00;
        held_len    = 6'd0;
        fill_count  = 6'd0;
        crc_lo      = 8'h00;
        run_crc     = crc16df_pkg::CRC_INIT;
    endtask

    task automatic absorb_rx_byte(input logic [7:0] b);
        logic [15:0] rcrc;
        case (parse_state)
            crc16df_pkg::ST_HDR0:
            begin
                if (b == hdr_first)
                begin
                    parse_state = crc16df_pkg::ST_HDR1;
                end
            end
            crc16df_pkg::ST_HDR1:
            begin
                if (b == hdr_second)
                begin
                    parse_state = crc16df_pkg::ST_TYPE;
                    run_crc = crc16df_pkg::CRC_INIT;
                end
                else if (b != hdr_first)
                begin
                    parse_state = crc16df_pkg::ST_HDR0;
                end
            end
            crc16df_pkg::ST_TYPE:
            begin
                held_type = b;
                run_crc = crc16_update(run_crc, b);
                parse_state = crc16df_pkg::ST_LEN;
            end
            crc16df_pkg::ST_LEN:
            begin
                if (b > 8'(MAX_PAYLOAD))
                begin
                    expect_result(crc16df_pkg::STATUS_OVERSIZE, 6'd0, 5'd0, 8'h00, 1'b0,
                                  16'h0000, 1'b1);
                    oversize_drops++;
                    restart_parser();
                end
                else
                begin
                    held_len = b[5:0];
                    run_crc = crc16_update(run_crc, b);
                    fill_count = 6'd0;
                    parse_state = (b == 8'd0) ? crc16df_pkg::ST_CRCLO : crc16df_pkg::ST_DATA;
                end
            end
            crc16df_pkg::ST_DATA:
            begin
                payload_copy[fill_count[4:0]] = b;
                run_crc = crc16_update(run_crc, b);
                fill_count = fill_count + 6'd1;
                if (fill_count >= held_len)
                begin
                    parse_state = crc16df_pkg::ST_CRCLO;
                end
            end
            crc16df_pkg::ST_CRCLO:
            begin
                crc_lo = b;
                parse_state = crc16df_pkg::ST_CRCHI;
            end
            crc16df_pkg::ST_CRCHI:
            begin
                rcrc = {b, crc_lo};
                if (rcrc != run_crc)
                begin
                    expect_result(crc16df_pkg::STATUS_BAD_CRC, held_len, 5'd0, 8'h00, 1'b0,
                                  rcrc, 1'b1);
                    crc_drops++;
                end
                else if (held_len == 6'd0)
                begin
                    expect_result(crc16df_pkg::STATUS_GOOD, 6'd0, 5'd0, 8'h00, 1'b0,
                                  rcrc, 1'b1);
                    good_packets++;
                    empty_packets++;
                end
                else
                begin
                    for (int i = 0; i < int'(held_len); i++)
                    begin
                        expect_result(crc16df_pkg::STATUS_GOOD, held_len, i[4:0],
                                      payload_copy[i[4:0]], 1'b1, rcrc,
                                      (6'(i + 1) == held_len));
                    end
                    good_packets++;
                end
                restart_parser();
            end
            default:
            begin
                restart_parser();
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t, result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(negedge clk)
    begin : drive_bytes
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        nxt_valid = in_valid;
        nxt_byte = rx_byte;
        if (byte_taken)
        begin
            nxt_valid = 1'b0;
            byte_taken = 1'b0;
        end
        if (rst_n && !nxt_valid)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_bytes.size() != 0)
            begin
                nxt_byte = pending_bytes.pop_front();
                nxt_valid = 1'b1;
                send_gap = draw_wait();
            end
        end
        in_valid <= nxt_valid;
        rx_byte <= nxt_byte;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            absorb_rx_byte(rx_byte);
            bytes_sent++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            stall_left = draw_wait();
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            out_taken = 1'b1;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, status 0x%0h data_byte 0x%0h",
                                          status, data_byte));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 16'(status), 16'(want.status));
                check_field("packet_type", 16'(packet_type), 16'(want.ptype));
                check_field("packet_length", 16'(packet_length), 16'(want.plen));
                check_field("byte_index", 16'(byte_index), 16'(want.index));
                check_field("data_byte", 16'(data_byte), 16'(want.data));
                check_field("data_valid", 16'(data_valid), 16'(want.dvalid));
                check_field("received_crc", received_crc, want.rcrc);
                check_field("last", 16'(last), 16'(want.last));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results still expected",
                     quiet_cycles, expected_results.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            crc16df_pkg::CFG_HEADER_FIRST:  hdr_first = val;
            crc16df_pkg::CFG_HEADER_SECOND: hdr_second = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_headers(input logic [7:0] first, input logic [7:0] second,
                               input bit with_spare);
        if (with_spare)
        begin
            write_reg(CFG_SPARE_LO, rand_byte());
            write_reg(CFG_SPARE_HI, rand_byte());
        end
        write_reg(crc16df_pkg::CFG_HEADER_FIRST, first);
        write_reg(crc16df_pkg::CFG_HEADER_SECOND, second);
        @(negedge clk);
        cfg_valid <= 1'b0;
        header_settings++;
    endtask

    task automatic wait_quiet();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic settle_parser();
        logic [7:0] filler;
        wait_quiet();
        while (parse_state != crc16df_pkg::ST_HDR0)
        begin
            case (parse_state)
                crc16df_pkg::ST_HDR1:
                begin
                    filler = hdr_first;
                    while (filler == hdr_first || filler == hdr_second)
                    begin
                        filler = filler + 8'd1;
                    end
                end
                crc16df_pkg::ST_LEN:  filler = 8'hFF;
                default: filler = rand_byte();
            endcase
            pending_bytes.push_back(filler);
            wait_quiet();
        end
    endtask

    task automatic queue_packet(input logic [7:0] ptype, input bit repeat_first,
                                input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  len;
        len = 8'(frame_body.size());
        crc = crc16_update(crc16df_pkg::CRC_INIT, ptype);
        crc = crc16_update(crc, len);
        foreach (frame_body[i])
        begin
            crc = crc16_update(crc, frame_body[i]);
        end
        if (corrupt)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        pending_bytes.push_back(hdr_first);
        if (repeat_first && hdr_first != hdr_second)
        begin
            pending_bytes.push_back(hdr_first);
        end
        pending_bytes.push_back(hdr_second);
        pending_bytes.push_back(ptype);
        pending_bytes.push_back(len);
        foreach (frame_body[i])
        begin
            pending_bytes.push_back(frame_body[i]);
        end
        pending_bytes.push_back(crc[7:0]);
        pending_bytes.push_back(crc[15:8]);
    endtask

    task automatic queue_oversize(input logic [7:0] ptype, input logic [7:0] len);
        pending_bytes.push_back(hdr_first);
        pending_bytes.push_back(hdr_second);
        pending_bytes.push_back(ptype);
        pending_bytes.push_back(len);
    endtask

    task automatic queue_random_frame();
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        frame_body.delete();
        case (pick)
            0:
            begin
                repeat ($urandom_range(1, 4)) pending_bytes.push_back(rand_byte());
            end
            1:
            begin
                queue_oversize(rand_byte(), 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end
            2:
            begin
                pending_bytes.push_back(hdr_first);
                pending_bytes.push_back(rand_byte());
            end
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       len = MAX_PAYLOAD;
                    1:       len = $urandom_range(9, MAX_PAYLOAD - 1);
                    default: len = $urandom_range(0, 8);
                endcase
                repeat (len) frame_body.push_back(rand_byte());
                queue_packet(rand_byte(), ($urandom_range(0, 3) == 0), (pick == 3));
            end
        endcase
    endtask

    task automatic run_random_phase();
        int start_size;
        start_size = pending_bytes.size();
        while (pending_bytes.size() - start_size < PHASE_BYTES)
        begin
            queue_random_frame();
        end
    endtask

    initial
    begin
        logic [7:0] same_hdr;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Noise, a repeated first header, an oversize length just past the
        // limit, an empty packet and a packet with a bad CRC.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        frame_body = '{8'h00, 8'hFF};
        queue_packet(8'hFF, 1'b1, 1'b0);
        queue_oversize(8'h00, 8'(MAX_PAYLOAD + 1));
        frame_body.delete();
        queue_packet(8'h5A, 1'b0, 1'b0);
        frame_body = '{8'hA5};
        queue_packet(8'h01, 1'b0, 1'b1);
        run_random_phase();
        settle_parser();

        set_headers(8'h00, 8'hFF, 1'b1);
        no_idle = 1'b1;
        run_random_phase();
        settle_parser();
        no_idle = 1'b0;

        set_headers(8'hFF, 8'h00, 1'b0);
        run_random_phase();
        settle_parser();

        same_hdr = rand_byte();
        set_headers(same_hdr, same_hdr, 1'b0);
        run_random_phase();
        settle_parser();

        set_headers(rand_byte(), rand_byte(), 1'b1);
        no_idle = 1'b1;
        run_random_phase();
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        settle_parser();
        no_idle = 1'b0;

        repeat (END_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end

        $display("Summary: %0d bytes sent and %0d results checked under %0d header settings",
                 bytes_sent, results_checked, header_settings);
        $display("Summary: %0d good packets (%0d empty), %0d oversize and %0d CRC drops",
                 good_packets, empty_packets, oversize_drops, crc_drops);
        if (error_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- crc16_packet_deframer.f -----
sv/crc16df_pkg.sv
sv/crc16df_ctrl.sv
sv/crc16df_dp.sv
sv/crc16_packet_deframer.sv
tb/testbench.sv
